// ===== hw/rtl/uv_sphere_vertex_generator_defines.svh =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator assertion macros
// Shared concurrent assertion forms for the vertex generator RTL.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define UVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator package
// Widths, register map, series constants and rounding helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int unsigned IDX_W   = 10;
    localparam int unsigned RAD_W   = 16;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned NRM_W   = 16;
    localparam int unsigned TEX_W   = 17;
    localparam int unsigned PH_W    = 32;
    localparam int unsigned SC_W    = 32;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SEGS   = 2'd1;
    localparam logic [1:0] REG_RINGS  = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
    localparam logic [IDX_W-1:0] SEGS_RST   = 10'd16;
    localparam logic [IDX_W-1:0] RINGS_RST  = 10'd8;
    localparam logic [IDX_W-1:0] SEGS_MIN   = 10'd3;
    localparam logic [IDX_W-1:0] RINGS_MIN  = 10'd2;

    localparam int unsigned DIV_LAT = 34;
    localparam int unsigned SC_LAT  = 14;
    localparam int unsigned OUT_LAT = 4;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [29:0] PI4_Q30  = 30'd843314857;
    localparam logic [29:0] HALF_OCT = 30'h2000_0000;
    localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;

    localparam int unsigned SC_STEPS = 5;
    localparam int unsigned SIN_DIV [SC_STEPS] = '{72, 42, 20, 6, 1};
    localparam int unsigned COS_DIV [SC_STEPS] = '{90, 56, 30, 12, 2};

    localparam logic signed [63:0] POS_MAX = 64'sd65535;
    localparam logic signed [63:0] POS_MIN = -64'sd65535;
    localparam logic signed [63:0] NRM_MAX = 64'sd32767;
    localparam logic signed [63:0] NRM_MIN = -64'sd32768;

    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? (64'd0 - v) : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
        return c[POS_W-1:0];
    endfunction

    function automatic logic [NRM_W-1:0] sat_nrm(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > NRM_MAX) ? NRM_MAX : ((v < NRM_MIN) ? NRM_MIN : v);
        return c[NRM_W-1:0];
    endfunction

    // remainder plus half divisor reaches divisor: round the quotient up
    function automatic logic rnd_up(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] d);
        return ({1'b0, r} + {2'b00, d[IDX_W-1:1]}) >= {1'b0, d};
    endfunction

endpackage

// ===== hw/rtl/uvs_chan_if.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator channels
// Valid/ready request and vertex channels.
// ----------------------------------------------------------------------------
interface uvs_in_if;
    logic                        valid;
    logic                        ready;
    logic [uvs_pkg::IDX_W-1:0]   ring_index;
    logic [uvs_pkg::IDX_W-1:0]   segment_index;

    modport source (output valid, ring_index, segment_index, input ready);
    modport sink   (input valid, ring_index, segment_index, output ready);
endinterface

interface uvs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [uvs_pkg::POS_W-1:0]  pos_x;
    logic signed [uvs_pkg::POS_W-1:0]  pos_y;
    logic signed [uvs_pkg::POS_W-1:0]  pos_z;
    logic signed [uvs_pkg::NRM_W-1:0]  normal_x;
    logic signed [uvs_pkg::NRM_W-1:0]  normal_y;
    logic signed [uvs_pkg::NRM_W-1:0]  normal_z;
    logic [uvs_pkg::TEX_W-1:0]         tex_u;
    logic [uvs_pkg::TEX_W-1:0]         tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    tex_u, tex_v, output ready);
endinterface

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator
// Grid point (ring, segment) in, sphere position, normal and texture out.
// ----------------------------------------------------------------------------
// Takes one request per clock while the pipeline is not held and returns one
// vertex per request, in order, through bit-per-stage index division, octant
// fold and Horner sine/cosine, then scaling and rounding.
// The whole pipeline advances together: it holds only while a finished vertex
// waits at the output register and the sink is not ready. Write the radius and
// counts only while no request is in flight; counts below 3 segments or 2 rings
// act as 3 and 2, and indices above a count saturate to that count.
module uv_sphere_vertex_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    uvs_in_if.sink                           i_req,
    uvs_out_if.source                        o_vtx,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [uvs_pkg::PADDR_W-1:0]      paddr,
    input  logic [uvs_pkg::PDATA_W-1:0]      pwdata,
    output logic [uvs_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import uvs_pkg::*;

    `include "uv_sphere_vertex_generator_defines.svh"

    logic [RAD_W-1:0]       r_radius;
    logic [IDX_W-1:0]       r_segs;
    logic [IDX_W-1:0]       r_rings;
    logic [IDX_W-1:0]       n_segs;
    logic [IDX_W-1:0]       n_rings;
    logic                   n_en;
    logic                   n_wr;
    logic                   w_div_vld;
    logic [PH_W-1:0]        w_az_ph;
    logic [PH_W-1:0]        w_pol_ph;
    logic [TEX_W-1:0]       w_tu;
    logic [TEX_W-1:0]       w_tv;
    logic                   w_az_vld;
    logic                   w_pol_vld;
    logic signed [SC_W-1:0] w_sin_az;
    logic signed [SC_W-1:0] w_cos_az;
    logic signed [SC_W-1:0] w_sin_pol;
    logic signed [SC_W-1:0] w_cos_pol;
    logic [TEX_W-1:0]       r_tu_d [SC_LAT];
    logic [TEX_W-1:0]       r_tv_d [SC_LAT];
    logic                   w_out_vld;
    logic [POS_W-1:0]       w_pos_x;
    logic [POS_W-1:0]       w_pos_y;
    logic [POS_W-1:0]       w_pos_z;
    logic [NRM_W-1:0]       w_nrm_x;
    logic [NRM_W-1:0]       w_nrm_y;
    logic [NRM_W-1:0]       w_nrm_z;
    logic [TEX_W-1:0]       w_tex_u;
    logic [TEX_W-1:0]       w_tex_v;

    assign n_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_segs   <= SEGS_RST;
            r_rings  <= RINGS_RST;
        end else if (n_wr) begin
            unique case (paddr[3:2])
                REG_RADIUS: r_radius <= pwdata[RAD_W-1:0];
                REG_SEGS:   r_segs   <= pwdata[IDX_W-1:0];
                REG_RINGS:  r_rings  <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RADIUS: prdata = PDATA_W'(r_radius);
            REG_SEGS:   prdata = PDATA_W'(r_segs);
            REG_RINGS:  prdata = PDATA_W'(r_rings);
            default:    prdata = '0;
        endcase
    end

    assign n_segs  = (r_segs < SEGS_MIN) ? SEGS_MIN : r_segs;
    assign n_rings = (r_rings < RINGS_MIN) ? RINGS_MIN : r_rings;

    // advance unless a vertex waits at the output and the sink is not ready
    assign n_en        = !w_out_vld || o_vtx.ready;
    assign i_req.ready = n_en;

    uvs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (n_en),
        .i_valid     (i_req.valid),
        .i_seg       (i_req.segment_index),
        .i_ring      (i_req.ring_index),
        .i_segs      (n_segs),
        .i_rings     (n_rings),
        .o_valid     (w_div_vld),
        .o_az_phase  (w_az_ph),
        .o_pol_phase (w_pol_ph),
        .o_tex_u     (w_tu),
        .o_tex_v     (w_tv)
    );

    uvs_sincos u_sc_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (w_div_vld),
        .i_phase (w_az_ph),
        .o_valid (w_az_vld),
        .o_sin   (w_sin_az),
        .o_cos   (w_cos_az)
    );

    uvs_sincos u_sc_pol (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (w_div_vld),
        .i_phase (w_pol_ph),
        .o_valid (w_pol_vld),
        .o_sin   (w_sin_pol),
        .o_cos   (w_cos_pol)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_tu_d[0] <= w_tu;
            r_tv_d[0] <= w_tv;
            for (int i = 1; i < SC_LAT; i++) begin
                r_tu_d[i] <= r_tu_d[i-1];
                r_tv_d[i] <= r_tv_d[i-1];
            end
        end
    end

    uvs_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (n_en),
        .i_valid    (w_az_vld),
        .i_sin_pol  (w_sin_pol),
        .i_cos_pol  (w_cos_pol),
        .i_sin_az   (w_sin_az),
        .i_cos_az   (w_cos_az),
        .i_radius   (r_radius),
        .i_tex_u    (r_tu_d[SC_LAT-1]),
        .i_tex_v    (r_tv_d[SC_LAT-1]),
        .o_valid    (w_out_vld),
        .o_pos_x    (w_pos_x),
        .o_pos_y    (w_pos_y),
        .o_pos_z    (w_pos_z),
        .o_normal_x (w_nrm_x),
        .o_normal_y (w_nrm_y),
        .o_normal_z (w_nrm_z),
        .o_tex_u    (w_tex_u),
        .o_tex_v    (w_tex_v)
    );

    assign o_vtx.valid    = w_out_vld;
    assign o_vtx.pos_x    = $signed(w_pos_x);
    assign o_vtx.pos_y    = $signed(w_pos_y);
    assign o_vtx.pos_z    = $signed(w_pos_z);
    assign o_vtx.normal_x = $signed(w_nrm_x);
    assign o_vtx.normal_y = $signed(w_nrm_y);
    assign o_vtx.normal_z = $signed(w_nrm_z);
    assign o_vtx.tex_u    = w_tex_u;
    assign o_vtx.tex_v    = w_tex_v;

    `UVS_ASSERT_NOW(a_lanes_aligned, i_clk, i_rst_n, 1'b1, w_az_vld == w_pol_vld, "sine lanes out of step")
    `UVS_ASSERT_NOW(a_tex_u_range, i_clk, i_rst_n, o_vtx.valid, o_vtx.tex_u <= TEX_ONE, "tex_u above one")
    `UVS_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, o_vtx.valid, w_pos_x != 17'h10000, "pos_x below range")
    `UVS_ASSERT_NEXT(a_radius_wr, i_clk, i_rst_n, n_wr && paddr[3:2] == REG_RADIUS, r_radius == $past(pwdata[RAD_W-1:0]), "radius write lost")

endmodule

// ===== hw/rtl/uvs_div.sv =====
// ----------------------------------------------------------------------------
// UV sphere grid divider
// Bit-per-stage restoring division of both grid indices by their counts.
// ----------------------------------------------------------------------------
module uvs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [uvs_pkg::IDX_W-1:0]   i_seg,
    input  logic [uvs_pkg::IDX_W-1:0]   i_ring,
    input  logic [uvs_pkg::IDX_W-1:0]   i_segs,
    input  logic [uvs_pkg::IDX_W-1:0]   i_rings,
    output logic                        o_valid,
    output logic [uvs_pkg::PH_W-1:0]    o_az_phase,
    output logic [uvs_pkg::PH_W-1:0]    o_pol_phase,
    output logic [uvs_pkg::TEX_W-1:0]   o_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]   o_tex_v
);
    import uvs_pkg::*;

    localparam int unsigned STEPS = 32;

    logic [DIV_LAT-1:0] r_vld;
    logic [IDX_W-1:0]   n_idx [2];
    logic [IDX_W-1:0]   n_cnt [2];
    logic [IDX_W-1:0]   n_num [2];
    logic               n_qi  [2];
    logic [IDX_W-1:0]   r_rem [2][STEPS+1];
    logic [IDX_W-1:0]   r_den [2][STEPS+1];
    logic [STEPS:0]     r_quo [2][STEPS+1];
    logic [TEX_W-1:0]   r_tex [2][17];
    logic [PH_W-1:0]    r_pph;
    logic [PH_W-1:0]    r_pph_o;
    logic [PH_W-1:0]    r_aph;

    assign n_idx[0] = i_seg;
    assign n_idx[1] = i_ring;
    assign n_cnt[0] = i_segs;
    assign n_cnt[1] = i_rings;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_LAT-2:0], i_valid};
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign n_num[l] = (n_idx[l] > n_cnt[l]) ? n_cnt[l] : n_idx[l];
        assign n_qi[l]  = (n_num[l] == n_cnt[l]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[l][0] <= n_cnt[l];
                r_quo[l][0] <= {{STEPS{1'b0}}, n_qi[l]};
                r_rem[l][0] <= n_qi[l] ? '0 : n_num[l];
            end
        end

        for (genvar k = 1; k <= STEPS; k++) begin : g_step
            logic [IDX_W:0] n_r2;
            logic           n_ge;
            assign n_r2 = {r_rem[l][k-1], 1'b0};
            assign n_ge = n_r2 >= {1'b0, r_den[l][k-1]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][k] <= n_ge ? IDX_W'(n_r2 - {1'b0, r_den[l][k-1]})
                                        : n_r2[IDX_W-1:0];
                    r_quo[l][k] <= {r_quo[l][k-1][STEPS-1:0], n_ge};
                    r_den[l][k] <= r_den[l][k-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tex[l][0] <= r_quo[l][16][TEX_W-1:0]
                             + TEX_W'(rnd_up(r_rem[l][16], r_den[l][16]));
                for (int i = 1; i < 17; i++) begin
                    r_tex[l][i] <= r_tex[l][i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pph   <= r_quo[1][31][PH_W-1:0] + PH_W'(rnd_up(r_rem[1][31], r_den[1][31]));
            r_pph_o <= r_pph;
            r_aph   <= r_quo[0][32][PH_W-1:0] + PH_W'(rnd_up(r_rem[0][32], r_den[0][32]));
        end
    end

    assign o_valid     = r_vld[DIV_LAT-1];
    assign o_az_phase  = r_aph;
    assign o_pol_phase = r_pph_o;
    assign o_tex_u     = r_tex[0][16];
    assign o_tex_v     = TEX_ONE - r_tex[1][16];

endmodule

// ===== hw/rtl/uvs_sincos.sv =====
// ----------------------------------------------------------------------------
// UV sphere sine/cosine pipeline
// Octant fold, radian scaling and pipelined Horner series in Q30.
// ----------------------------------------------------------------------------
module uvs_sincos (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [uvs_pkg::PH_W-1:0]          i_phase,
    output logic                              o_valid,
    output logic signed [uvs_pkg::SC_W-1:0]   o_sin,
    output logic signed [uvs_pkg::SC_W-1:0]   o_cos
);
    import uvs_pkg::*;

    logic [SC_LAT-1:0]      r_vld;
    logic [2:0]             r_oct [13];
    logic [29:0]            n_f;
    logic [29:0]            r_f;
    logic [59:0]            n_xp;
    logic [29:0]            r_x;
    logic [59:0]            n_x2p;
    logic [29:0]            r_lx  [11];
    logic [29:0]            r_lx2 [11];
    logic [29:0]            r_sp  [SC_STEPS];
    logic [29:0]            r_cp  [SC_STEPS];
    logic [30:0]            r_st  [SC_STEPS];
    logic [30:0]            r_ct  [SC_STEPS];
    logic [30:0]            n_st_in [SC_STEPS+1];
    logic [30:0]            n_ct_in [SC_STEPS+1];
    logic signed [SC_W-1:0] n_a;
    logic signed [SC_W-1:0] n_b;
    logic signed [SC_W-1:0] r_sin;
    logic signed [SC_W-1:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SC_LAT-2:0], i_valid};
        end
    end

    // reflect odd octants
    assign n_f   = i_phase[29] ? 30'(HALF_OCT - {1'b0, i_phase[28:0]})
                               : {1'b0, i_phase[28:0]};
    assign n_xp  = 60'(r_f) * 60'(PI4_Q30);
    assign n_x2p = 60'(r_x) * 60'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oct[0] <= i_phase[31:29];
            r_f      <= n_f;
            r_oct[1] <= r_oct[0];
            r_x      <= n_xp[58:29];
            r_oct[2] <= r_oct[1];
            r_lx[0]  <= r_x;
            r_lx2[0] <= n_x2p[59:30];
            for (int i = 1; i < 11; i++) begin
                r_lx[i]    <= r_lx[i-1];
                r_lx2[i]   <= r_lx2[i-1];
                r_oct[i+2] <= r_oct[i+1];
            end
        end
    end

    assign n_st_in[0] = Q30_ONE;
    assign n_ct_in[0] = Q30_ONE;

    for (genvar j = 0; j < SC_STEPS; j++) begin : g_horner
        localparam int unsigned CK = 30 + $clog2(COS_DIV[j]);
        localparam logic [31:0] CM =
            32'(((64'd1 << CK) + 64'(COS_DIV[j]) - 64'd1) / 64'(COS_DIV[j]));
        logic [60:0] n_sprod;
        logic [60:0] n_cprod;
        logic [61:0] n_cq;

        assign n_st_in[j+1] = r_st[j];
        assign n_ct_in[j+1] = r_ct[j];
        assign n_cprod      = 61'(r_lx2[2*j]) * 61'(n_ct_in[j]);
        assign n_cq         = 62'(r_cp[j]) * 62'(CM);

        if (j < SC_STEPS - 1) begin : g_sin_step
            localparam int unsigned SK = 30 + $clog2(SIN_DIV[j]);
            localparam logic [31:0] SM =
                32'(((64'd1 << SK) + 64'(SIN_DIV[j]) - 64'd1) / 64'(SIN_DIV[j]));
            logic [61:0] n_sq;
            assign n_sprod = 61'(r_lx2[2*j]) * 61'(n_st_in[j]);
            assign n_sq    = 62'(r_sp[j]) * 62'(SM);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[j] <= Q30_ONE - 31'(n_sq >> SK);
                end
            end
        end else begin : g_sin_last
            assign n_sprod = 61'(r_lx[2*j]) * 61'(n_st_in[j]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[j] <= {1'b0, r_sp[j]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sp[j] <= n_sprod[59:30];
                r_cp[j] <= n_cprod[59:30];
                r_ct[j] <= Q30_ONE - 31'(n_cq >> CK);
            end
        end
    end

    assign n_a = $signed({1'b0, r_st[SC_STEPS-1]});
    assign n_b = $signed({1'b0, r_ct[SC_STEPS-1]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_oct[12])
                3'd0: begin r_sin <= n_a;  r_cos <= n_b;  end
                3'd1: begin r_sin <= n_b;  r_cos <= n_a;  end
                3'd2: begin r_sin <= n_b;  r_cos <= -n_a; end
                3'd3: begin r_sin <= n_a;  r_cos <= -n_b; end
                3'd4: begin r_sin <= -n_a; r_cos <= -n_b; end
                3'd5: begin r_sin <= -n_b; r_cos <= -n_a; end
                3'd6: begin r_sin <= -n_b; r_cos <= n_a;  end
                default: begin r_sin <= -n_a; r_cos <= n_b; end
            endcase
        end
    end

    assign o_valid = r_vld[SC_LAT-1];
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

// ===== hw/rtl/uvs_out.sv =====
// ----------------------------------------------------------------------------
// UV sphere vertex output stage
// Normal products, radius scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module uvs_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [uvs_pkg::SC_W-1:0]   i_sin_pol,
    input  logic signed [uvs_pkg::SC_W-1:0]   i_cos_pol,
    input  logic signed [uvs_pkg::SC_W-1:0]   i_sin_az,
    input  logic signed [uvs_pkg::SC_W-1:0]   i_cos_az,
    input  logic [uvs_pkg::RAD_W-1:0]         i_radius,
    input  logic [uvs_pkg::TEX_W-1:0]         i_tex_u,
    input  logic [uvs_pkg::TEX_W-1:0]         i_tex_v,
    output logic                              o_valid,
    output logic [uvs_pkg::POS_W-1:0]         o_pos_x,
    output logic [uvs_pkg::POS_W-1:0]         o_pos_y,
    output logic [uvs_pkg::POS_W-1:0]         o_pos_z,
    output logic [uvs_pkg::NRM_W-1:0]         o_normal_x,
    output logic [uvs_pkg::NRM_W-1:0]         o_normal_y,
    output logic [uvs_pkg::NRM_W-1:0]         o_normal_z,
    output logic [uvs_pkg::TEX_W-1:0]         o_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]         o_tex_v
);
    import uvs_pkg::*;

    logic [OUT_LAT-1:0]     r_vld;
    logic signed [63:0]     r_px;
    logic signed [63:0]     r_pz;
    logic signed [SC_W-1:0] r_ny1;
    logic signed [SC_W-1:0] r_n   [3];
    logic signed [48:0]     n_m   [3];
    logic signed [48:0]     r_m   [3];
    logic [NRM_W-1:0]       r_nq3 [3];
    logic [POS_W-1:0]       r_pos [3];
    logic [NRM_W-1:0]       r_nq  [3];
    logic [TEX_W-1:0]       r_tu  [OUT_LAT];
    logic [TEX_W-1:0]       r_tv  [OUT_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[OUT_LAT-2:0], i_valid};
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_comp
        assign n_m[c] = 49'(r_n[c]) * 49'($signed({1'b0, i_radius}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= 64'(i_sin_pol) * 64'(i_cos_az);
            r_pz  <= 64'(i_sin_pol) * 64'(i_sin_az);
            r_ny1 <= i_cos_pol;
            r_n[0] <= SC_W'(rnd_shr(r_px, 30));
            r_n[1] <= r_ny1;
            r_n[2] <= SC_W'(rnd_shr(r_pz, 30));
            for (int c = 0; c < 3; c++) begin
                r_m[c]   <= n_m[c];
                r_nq3[c] <= sat_nrm(rnd_shr(64'(r_n[c]), 15));
                r_pos[c] <= sat_pos(rnd_shr(64'(r_m[c]), 30));
                r_nq[c]  <= r_nq3[c];
            end
            r_tu[0] <= i_tex_u;
            r_tv[0] <= i_tex_v;
            for (int i = 1; i < OUT_LAT; i++) begin
                r_tu[i] <= r_tu[i-1];
                r_tv[i] <= r_tv[i-1];
            end
        end
    end

    assign o_valid    = r_vld[OUT_LAT-1];
    assign o_pos_x    = r_pos[0];
    assign o_pos_y    = r_pos[1];
    assign o_pos_z    = r_pos[2];
    assign o_normal_x = r_nq[0];
    assign o_normal_y = r_nq[1];
    assign o_normal_z = r_nq[2];
    assign o_tex_u    = r_tu[OUT_LAT-1];
    assign o_tex_v    = r_tv[OUT_LAT-1];

endmodule
